[src/max_unpool_nchwc8_scatter_top_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the max-unpooling scatter block
// Shared concurrent-assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MAX_UNPOOL_NCHWC8_SCATTER_TOP_DEFINES_SVH
`define MAX_UNPOOL_NCHWC8_SCATTER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define MUP8_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// condition must never be seen outside reset
`define MUP8_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MUP8_ASSERT(lbl, prop, msg)
`define MUP8_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

[src/mup8_pkg.sv]
// ----------------------------------------------------------------------------
// mup8_pkg
// Shared widths, register codes and item types of the max-unpooling scatter.
// ----------------------------------------------------------------------------
`default_nettype none

package mup8_pkg;

  localparam int unsigned IndexW  = 31;           // index and address width
  localparam int unsigned ValW    = 32;           // float bit pattern
  localparam int unsigned ChW     = 13;           // dimension register width
  localparam int unsigned HwW     = 2 * ChW;      // height*width product
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned Lanes   = 8;
  localparam int unsigned LaneW   = $clog2(Lanes);

  typedef enum logic [CfgIdxW-1:0] {
    RegChannels = 2'd0,
    RegHeight   = 2'd1,
    RegWidth    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [ValW-1:0]   pooled_value;
    logic [IndexW-1:0] source_index;
  } in_item_t;

  typedef struct packed {
    logic [IndexW-1:0] write_address;
    logic [ValW-1:0]   write_value;
  } out_item_t;

  // effective dimensions, zero already read as one
  typedef struct packed {
    logic [ChW-1:0] ch;
    logic [HwW-1:0] hw;
  } cfg_t;

endpackage

`default_nettype wire

[src/mup8_cfg.sv]
// ----------------------------------------------------------------------------
// mup8_cfg
// Dimension registers; keeps channels and the height*width product ready.
// ----------------------------------------------------------------------------
`default_nettype none

`include "max_unpool_nchwc8_scatter_top_defines.svh"

module mup8_cfg
  import mup8_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ChW-1:0]     cfg_wdata_i,
  output cfg_t               cfg_o
);

  logic [ChW-1:0] ch_q, ch_d;
  logic [ChW-1:0] h_q, h_d;
  logic [ChW-1:0] w_q, w_d;
  logic [HwW-1:0] hw_q, hw_d;
  logic [ChW-1:0] eff;

  // a zero dimension reads as one
  assign eff = (cfg_wdata_i == '0) ? ChW'(1) : cfg_wdata_i;

  always_comb begin
    ch_d = ch_q;
    h_d  = h_q;
    w_d  = w_q;
    hw_d = hw_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegChannels: begin
          ch_d = eff;
        end
        RegHeight: begin
          h_d  = eff;
          hw_d = HwW'(eff) * HwW'(w_q);
        end
        RegWidth: begin
          w_d  = eff;
          hw_d = HwW'(h_q) * HwW'(eff);
        end
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= ChW'(Lanes);
      h_q  <= ChW'(1);
      w_q  <= ChW'(1);
      hw_q <= HwW'(1);
    end else begin
      ch_q <= ch_d;
      h_q  <= h_d;
      w_q  <= w_d;
      hw_q <= hw_d;
    end
  end

  assign cfg_o.ch = ch_q;
  assign cfg_o.hw = hw_q;

  `MUP8_ASSERT(a_hw_product, hw_q == (HwW'(h_q) * HwW'(w_q)), "hw product out of step")
  `MUP8_ASSERT_NEVER(a_zero_dim, (ch_q == '0) || (h_q == '0) || (w_q == '0), "zero dimension held")

endmodule

`default_nettype wire

[src/mup8_front.sv]
// ----------------------------------------------------------------------------
// mup8_front
// Input side: accepts items into a two-entry queue that feeds the back end.
// ----------------------------------------------------------------------------
`default_nettype none

`include "max_unpool_nchwc8_scatter_top_defines.svh"

module mup8_front
  import mup8_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  output logic     valid_o,
  input  logic     pop_i,
  output in_item_t item_o
);

  localparam int unsigned Depth = 2;

  in_item_t   mem_q [Depth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_stall_o = (cnt_q == 2'(Depth));
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = pop_i && (cnt_q != 2'd0);
  assign valid_o    = (cnt_q != 2'd0);
  assign item_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

  `MUP8_ASSERT(a_pop_nonempty, pop_i |-> (cnt_q != 2'd0), "pop from empty queue")
  `MUP8_ASSERT(a_push_shows, (push && (cnt_q == 2'd0)) |=> valid_o, "pushed item not presented")

endmodule

`default_nettype wire

[src/mup8_back.sv]
// ----------------------------------------------------------------------------
// mup8_back
// Address pipeline: index / (h*w), quotient % channels, one multiply, output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "max_unpool_nchwc8_scatter_top_defines.svh"

module mup8_back
  import mup8_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      in_valid_i,
  output logic      pop_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int unsigned Last = IndexW - 1;

  // address = (q1 - c8)*hw + spatial*8 + c8, q1 = idx / hw, c8 = (q1 % ch) % 8

  logic adv;

  // first divider: idx by hw, one quotient bit per stage
  logic              d1_vld_q [IndexW];
  logic [HwW-1:0]    d1_rem_q [IndexW];
  logic [IndexW-1:0] d1_num_q [IndexW];
  logic [ValW-1:0]   d1_val_q [IndexW];

  // second divider: q1 by ch, remainder only
  logic              d2_vld_q [IndexW];
  logic [ChW-1:0]    d2_rem_q [IndexW];
  logic [IndexW-1:0] d2_q1_q  [IndexW];
  logic [HwW-1:0]    d2_sp_q  [IndexW];
  logic [ValW-1:0]   d2_val_q [IndexW];

  // multiply stage
  logic                     m_vld_q;
  logic [IndexW-1:0]        m_prod_q;
  logic [HwW-1:0]           m_sp_q;
  logic [LaneW-1:0]         m_c8_q;
  logic [ValW-1:0]          m_val_q;
  logic [LaneW-1:0]         c8;
  logic [IndexW-1:0]        base;
  logic [IndexW+HwW-1:0]    prod_full;

  // output register
  logic      out_vld_q;
  out_item_t out_q;
  logic [IndexW-1:0] addr;

  // freeze the whole pipeline while the output is held
  assign adv   = !out_vld_q || !out_stall_i;
  assign pop_o = adv && in_valid_i;

  for (genvar k = 0; k < IndexW; k++) begin : g_div1
    logic              vld_in;
    logic [HwW-1:0]    r_in;
    logic [IndexW-1:0] n_in;
    logic [ValW-1:0]   v_in;
    logic [HwW:0]      trial;
    logic [HwW:0]      diff;
    logic              ge;

    if (k == 0) begin : g_src
      assign vld_in = in_valid_i;
      assign r_in   = '0;
      assign n_in   = in_item_i.source_index;
      assign v_in   = in_item_i.pooled_value;
    end else begin : g_src
      assign vld_in = d1_vld_q[k-1];
      assign r_in   = d1_rem_q[k-1];
      assign n_in   = d1_num_q[k-1];
      assign v_in   = d1_val_q[k-1];
    end

    assign trial = {r_in, n_in[IndexW-1]};
    assign diff  = trial - {1'b0, cfg_i.hw};
    assign ge    = (trial >= {1'b0, cfg_i.hw});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d1_vld_q[k] <= 1'b0;
      end else if (adv) begin
        d1_vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        d1_rem_q[k] <= ge ? diff[HwW-1:0] : trial[HwW-1:0];
        d1_num_q[k] <= {n_in[IndexW-2:0], ge};
        d1_val_q[k] <= v_in;
      end
    end
  end

  for (genvar k = 0; k < IndexW; k++) begin : g_div2
    logic              vld_in;
    logic [ChW-1:0]    r_in;
    logic [IndexW-1:0] q1_in;
    logic [HwW-1:0]    sp_in;
    logic [ValW-1:0]   v_in;
    logic [ChW:0]      trial;
    logic [ChW:0]      diff;
    logic              ge;

    if (k == 0) begin : g_src
      assign vld_in = d1_vld_q[Last];
      assign r_in   = '0;
      assign q1_in  = d1_num_q[Last];
      assign sp_in  = d1_rem_q[Last];
      assign v_in   = d1_val_q[Last];
    end else begin : g_src
      assign vld_in = d2_vld_q[k-1];
      assign r_in   = d2_rem_q[k-1];
      assign q1_in  = d2_q1_q[k-1];
      assign sp_in  = d2_sp_q[k-1];
      assign v_in   = d2_val_q[k-1];
    end

    assign trial = {r_in, q1_in[Last-k]};
    assign diff  = trial - {1'b0, cfg_i.ch};
    assign ge    = (trial >= {1'b0, cfg_i.ch});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d2_vld_q[k] <= 1'b0;
      end else if (adv) begin
        d2_vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        d2_rem_q[k] <= ge ? diff[ChW-1:0] : trial[ChW-1:0];
        d2_q1_q[k]  <= q1_in;
        d2_sp_q[k]  <= sp_in;
        d2_val_q[k] <= v_in;
      end
    end
  end

  // q1 - c8 is q1 rounded down to a whole channel block
  assign c8        = d2_rem_q[Last][LaneW-1:0];
  assign base      = d2_q1_q[Last] - IndexW'(c8);
  assign prod_full = (IndexW+HwW)'(base) * (IndexW+HwW)'(cfg_i.hw);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else if (adv) begin
      m_vld_q <= d2_vld_q[Last];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_prod_q <= prod_full[IndexW-1:0];
      m_sp_q   <= d2_sp_q[Last];
      m_c8_q   <= c8;
      m_val_q  <= d2_val_q[Last];
    end
  end

  // wrap to the address width
  assign addr = m_prod_q + IndexW'({m_sp_q, m_c8_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= m_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.write_address <= addr;
      out_q.write_value   <= m_val_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `MUP8_ASSERT(a_rem1_range, d1_vld_q[Last] |-> (d1_rem_q[Last] < cfg_i.hw), "spatial offset not below h*w")
  `MUP8_ASSERT(a_rem2_range, d2_vld_q[Last] |-> (d2_rem_q[Last] < cfg_i.ch), "channel not below channel count")

endmodule

`default_nettype wire

[src/max_unpool_nchwc8_scatter_top.sv]
// ----------------------------------------------------------------------------
// max_unpool_nchwc8_scatter_top
// Max-unpooling scatter: turns a flat NCHW index into an NCHWC8 address.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid_i / in_stall_o with in_data_i (pooled value and
//   flat NCHW source index). Output channel: out_valid_o / out_stall_i with
//   out_data_o (NCHWC8 write address and the value unchanged). An item moves
//   on a clock edge with valid high and stall low.
//   Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
//   (channels, height, width); write only while no item is in flight.
//   Throughput: one item per cycle while the output is not held. From acceptance to
//   out_valid_o an item passes the input queue, the two bit-per-stage divider
//   pipelines (31 stages each), one multiply stage and the output register.
//   Reset clears all valid flags and loads channels = 8, height = width = 1.
//   While out_stall_i is high with an item at the output the whole pipeline
//   holds; the two-entry input queue then fills and in_stall_o rises.
// ----------------------------------------------------------------------------
`default_nettype none

module max_unpool_nchwc8_scatter_top
  import mup8_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ChW-1:0]     cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_data_o
);

  cfg_t     cfg;
  logic     q_valid;
  logic     q_pop;
  in_item_t q_item;

  mup8_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  mup8_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .valid_o    (q_valid),
    .pop_i      (q_pop),
    .item_o     (q_item)
  );

  mup8_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (q_valid),
    .pop_o       (q_pop),
    .in_item_i   (q_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
